// ===== rtl/swg_pkg.sv =====
`timescale 1ns / 1ps

package swg_pkg;

  localparam int GATE_W       = 16;
  localparam int UP_W         = 16;
  localparam int OUT_W        = 32;
  localparam int MAG_W        = 16;
  localparam int E_W          = 17;
  localparam int S_W          = 17;
  localparam int FRAC_W       = 15;
  localparam int DEN_W        = 18;
  localparam int REM_W        = DEN_W - 1;
  localparam int NUM_W        = 33;
  localparam int PROD1_W      = MAG_W + S_W;
  localparam int PROD2_W      = PROD1_W + MAG_W;
  localparam int ROUND_SHIFT  = 16;
  localparam int TAYLOR_TERMS = 24;

  localparam int DEFAULT_EXP_TABLE_ENTRIES = 256;

  localparam logic [E_W-1:0] Q16_ONE = 17'h10000;

  typedef struct packed {
    logic             gneg;
    logic             uneg;
    logic [MAG_W-1:0] gmag;
    logic [MAG_W-1:0] umag;
  } swg_side_t;

endpackage

// ===== rtl/swg_exp.sv =====
`timescale 1ns / 1ps

module swg_exp
  import swg_pkg::*;
#(
  parameter int EXP_TABLE_ENTRIES = DEFAULT_EXP_TABLE_ENTRIES
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic signed [GATE_W-1:0] gate_value,
  input  logic signed [UP_W-1:0]   up_value,
  output logic                    out_valid,
  input  logic                    out_ready,
  output swg_side_t               out_side,
  output logic [E_W-1:0]          out_exp
);

  localparam int IDX_W = $clog2(EXP_TABLE_ENTRIES + 1);
  localparam int P_W   = MAG_W + IDX_W;
  localparam logic [63:0] ONE_Q32  = 64'd1 << 32;
  localparam logic [63:0] STEP_Q32 = (64'd8 << 32) / EXP_TABLE_ENTRIES;

  typedef logic [2*E_W-1:0] rom_row_t;
  typedef rom_row_t rom_t [0:EXP_TABLE_ENTRIES];

  // each row holds the entry and its drop to the next entry
  function automatic rom_t build_rom(input logic [63:0] step);
    rom_t        rows;
    logic [63:0] term;
    logic [63:0] ratio;
    logic [63:0] chain;
    logic [63:0] prev_e;
    logic [63:0] cur_e;
    logic [63:0] diff;
    term  = ONE_Q32;
    ratio = ONE_Q32;
    chain = ONE_Q32;
    for (int k = 1; k <= TAYLOR_TERMS; k++) begin
      term = ((term * step) >> 32) / 64'(k);
      if ((k % 2) == 1) begin
        ratio = ratio - term;
      end else begin
        ratio = ratio + term;
      end
    end
    prev_e = (chain + 64'h8000) >> 16;
    for (int k = 1; k <= EXP_TABLE_ENTRIES; k++) begin
      chain = (chain * ratio + (64'd1 << 31)) >> 32;
      cur_e = (chain + 64'h8000) >> 16;
      diff  = (cur_e > prev_e) ? 64'd0 : (prev_e - cur_e);
      rows[k-1] = {prev_e[E_W-1:0], diff[E_W-1:0]};
      prev_e = cur_e;
    end
    rows[EXP_TABLE_ENTRIES] = {prev_e[E_W-1:0], {E_W{1'b0}}};
    return rows;
  endfunction

  localparam rom_t EXP_ROM = build_rom(STEP_Q32);

  logic             rdy_a, rdy_b, rdy_c;
  logic             vld_a, vld_b, vld_c;
  swg_side_t        side_a, side_b, side_c;
  logic [IDX_W-1:0] idx_a;
  logic [FRAC_W-1:0] frac_a, frac_b;
  rom_row_t         row_b;
  logic [E_W-1:0]   exp_c;

  logic [MAG_W-1:0] gate_bits, up_bits, gmag, umag;
  logic [P_W-1:0]   pos;
  logic [E_W-1:0]   lo_b, diff_b;
  logic [31:0]      slope;
  logic [32:0]      corr;

  assign rdy_c    = ~vld_c | out_ready;
  assign rdy_b    = ~vld_b | rdy_c;
  assign rdy_a    = ~vld_a | rdy_b;
  assign in_ready = rdy_a;

  assign gate_bits = gate_value;
  assign up_bits   = up_value;
  assign gmag = gate_bits[MAG_W-1] ? (~gate_bits + 1'b1) : gate_bits;
  assign umag = up_bits[MAG_W-1] ? (~up_bits + 1'b1) : up_bits;
  assign pos  = P_W'(gmag) * P_W'(EXP_TABLE_ENTRIES);

  assign lo_b   = row_b[2*E_W-1:E_W];
  assign diff_b = row_b[E_W-1:0];
  assign slope  = 32'(diff_b) * 32'(frac_b);
  assign corr   = (33'(slope) + 33'h4000) >> FRAC_W;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld_a <= 1'b0;
      vld_b <= 1'b0;
      vld_c <= 1'b0;
    end else begin
      if (rdy_a) begin
        vld_a <= in_valid;
      end
      if (rdy_b) begin
        vld_b <= vld_a;
      end
      if (rdy_c) begin
        vld_c <= vld_b;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rdy_a) begin
      side_a.gneg <= gate_bits[MAG_W-1];
      side_a.uneg <= up_bits[MAG_W-1];
      side_a.gmag <= gmag;
      side_a.umag <= umag;
      idx_a       <= pos[FRAC_W +: IDX_W];
      frac_a      <= pos[FRAC_W-1:0];
    end
    if (rdy_b) begin
      side_b <= side_a;
      frac_b <= frac_a;
      row_b  <= EXP_ROM[idx_a];
    end
    if (rdy_c) begin
      side_c <= side_b;
      exp_c  <= lo_b - corr[E_W-1:0];
    end
  end

  assign out_valid = vld_c;
  assign out_side  = side_c;
  assign out_exp   = exp_c;

endmodule

// ===== rtl/swg_div.sv =====
`timescale 1ns / 1ps

module swg_div
  import swg_pkg::*;
(
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  swg_side_t      in_side,
  input  logic [E_W-1:0] in_exp,
  output logic           out_valid,
  input  logic           out_ready,
  output swg_side_t      out_side,
  output logic [S_W-1:0] out_sig
);

  logic [S_W+1:0]   rdy;
  logic             vld  [0:S_W];
  swg_side_t        side [0:S_W];
  logic [DEN_W-1:0] den  [0:S_W];
  logic [S_W-1:0]   nlo  [0:S_W];
  logic [REM_W-1:0] rem  [0:S_W];
  logic [S_W-1:0]   quo  [0:S_W];

  logic [DEN_W-1:0] den_in;
  logic [NUM_W-1:0] num_in;

  assign den_in = DEN_W'(Q16_ONE) + DEN_W'(in_exp);
  assign num_in = (in_side.gneg ? {in_exp, 16'h0000} : (NUM_W'(1) << 32))
                  + NUM_W'(den_in >> 1);

  assign rdy[S_W+1] = out_ready;
  assign rdy[0]     = ~vld[0] | rdy[1];
  assign in_ready   = rdy[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld[0] <= 1'b0;
    end else if (rdy[0]) begin
      vld[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[0]) begin
      side[0] <= in_side;
      den[0]  <= den_in;
      nlo[0]  <= num_in[S_W-1:0];
      rem[0]  <= REM_W'(num_in[NUM_W-1:S_W]);
      quo[0]  <= '0;
    end
  end

  for (genvar j = 1; j <= S_W; j++) begin : g_step
    logic [DEN_W-1:0] trial;
    logic             geq;

    assign trial  = {rem[j-1], nlo[j-1][S_W-j]};
    assign geq    = trial >= den[j-1];
    assign rdy[j] = ~vld[j] | rdy[j+1];

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[j] <= 1'b0;
      end else if (rdy[j]) begin
        vld[j] <= vld[j-1];
      end
    end

    always_ff @(posedge clk) begin
      if (rdy[j]) begin
        side[j] <= side[j-1];
        den[j]  <= den[j-1];
        nlo[j]  <= nlo[j-1];
        rem[j]  <= geq ? REM_W'(trial - den[j-1]) : trial[REM_W-1:0];
        quo[j]  <= {quo[j-1][S_W-2:0], geq};
      end
    end
  end

  assign out_valid = vld[S_W];
  assign out_side  = side[S_W];
  assign out_sig   = quo[S_W];

endmodule

// ===== rtl/swg_mul.sv =====
`timescale 1ns / 1ps

module swg_mul
  import swg_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  swg_side_t               in_side,
  input  logic [S_W-1:0]          in_sig,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic signed [OUT_W-1:0] gated_value
);

  logic               rdy_1, rdy_2, rdy_3;
  logic               vld_1, vld_2, vld_3;
  logic [PROD1_W-1:0] prod_1;
  logic [MAG_W-1:0]   umag_1;
  logic               neg_1, neg_2;
  logic [PROD2_W-1:0] prod_2;
  logic [PROD2_W-1:0] rounded;
  logic [OUT_W-1:0]   mag_r;
  logic [OUT_W-1:0]   result;

  assign rdy_3    = ~vld_3 | out_ready;
  assign rdy_2    = ~vld_2 | rdy_3;
  assign rdy_1    = ~vld_1 | rdy_2;
  assign in_ready = rdy_1;

  assign rounded = prod_2 + PROD2_W'(32'h8000);
  assign mag_r   = rounded[ROUND_SHIFT +: OUT_W];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld_1 <= 1'b0;
      vld_2 <= 1'b0;
      vld_3 <= 1'b0;
    end else begin
      if (rdy_1) begin
        vld_1 <= in_valid;
      end
      if (rdy_2) begin
        vld_2 <= vld_1;
      end
      if (rdy_3) begin
        vld_3 <= vld_2;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rdy_1) begin
      prod_1 <= PROD1_W'(in_side.gmag) * PROD1_W'(in_sig);
      umag_1 <= in_side.umag;
      neg_1  <= in_side.gneg ^ in_side.uneg;
    end
    if (rdy_2) begin
      prod_2 <= PROD2_W'(prod_1) * PROD2_W'(umag_1);
      neg_2  <= neg_1;
    end
    if (rdy_3) begin
      result <= neg_2 ? (~mag_r + 1'b1) : mag_r;
    end
  end

  assign out_valid   = vld_3;
  assign gated_value = result;

endmodule

// ===== rtl/swiglu_gate_activation.sv =====
`timescale 1ns / 1ps

// SwiGLU gating, silu(gate) * up, on Q4.12 inputs with a Q8.24 result. One beat
// is taken every cycle while the output side is ready, and each result passes
// through 3 stages for the exp table lookup and interpolation, 18 for the pipelined
// one-bit-per-stage sigmoid divider and 3 for the two multiplies and rounding.
// Every stage has its own ready, so a stall on the output side fills empty
// stages first and input beats keep being taken until the pipe is full. The
// exp table holds EXP_TABLE_ENTRIES+1 rows and is computed at elaboration, so
// the block needs no warm-up after reset.

module swiglu_gate_activation
  import swg_pkg::*;
#(
  parameter int EXP_TABLE_ENTRIES = DEFAULT_EXP_TABLE_ENTRIES
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,  // gate_value[15:0], up_value[31:16]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata   // gated_value[31:0]
);

  logic           exp_valid, exp_ready;
  swg_side_t      exp_side;
  logic [E_W-1:0] exp_value;
  logic           div_valid, div_ready;
  swg_side_t      div_side;
  logic [S_W-1:0] div_sig;
  logic signed [OUT_W-1:0] gated_value;

  swg_exp #(
    .EXP_TABLE_ENTRIES(EXP_TABLE_ENTRIES)
  ) u_exp (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (s_tvalid),
    .in_ready   (s_tready),
    .gate_value (s_tdata[GATE_W-1:0]),
    .up_value   (s_tdata[GATE_W +: UP_W]),
    .out_valid  (exp_valid),
    .out_ready  (exp_ready),
    .out_side   (exp_side),
    .out_exp    (exp_value)
  );

  swg_div u_div (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (exp_valid),
    .in_ready  (exp_ready),
    .in_side   (exp_side),
    .in_exp    (exp_value),
    .out_valid (div_valid),
    .out_ready (div_ready),
    .out_side  (div_side),
    .out_sig   (div_sig)
  );

  swg_mul u_mul (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (div_valid),
    .in_ready    (div_ready),
    .in_side     (div_side),
    .in_sig      (div_sig),
    .out_valid   (m_tvalid),
    .out_ready   (m_tready),
    .gated_value (gated_value)
  );

  assign m_tdata = gated_value;

  a_ready_follows_out: assert property (@(posedge clk) disable iff (rst)
    m_tready |-> s_tready)
    else $error("input stalled while output side is ready");

  a_reset_empties: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("output beat valid right after reset");

  a_exp_range: assert property (@(posedge clk) disable iff (rst)
    exp_valid |-> (exp_value <= Q16_ONE))
    else $error("exp value above one");

  a_sig_range: assert property (@(posedge clk) disable iff (rst)
    div_valid |-> (div_sig <= Q16_ONE))
    else $error("sigmoid above one");

endmodule
